/* sv/rau_pkg.sv */
// rau_pkg: widths, codes and shared types of the rational arithmetic unit
// no dependencies; used by rau_reduce, rau_mul and rational_arith_unit
package rau_pkg;

	// operand field width
	localparam int OPW   = 16;
	// magnitude of a reduced part, up to 2^(OPW-1)
	localparam int MAGW  = OPW;
	// signed reduced numerator
	localparam int NUMW  = OPW + 1;
	// full signed product of two reduced parts
	localparam int PRODW = 2 * NUMW;
	// result field widths
	localparam int RNUMW = 33;
	localparam int RDENW = 32;
	// step counter of the divider
	localparam int CNTW  = $clog2(MAGW);

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RED_A,
		S_RED_B,
		S_MUL
	} top_state_t;

	typedef enum logic [1:0] {
		R_IDLE,
		R_GCD,
		R_DIVN,
		R_DIVD
	} red_state_t;

	// reduced fraction, denominator always positive
	typedef struct packed {
		logic signed [NUMW-1:0] num;
		logic [MAGW-1:0]        den;
	} frac_t;

	// comparison flags
	typedef struct packed {
		logic eq;
		logic lt;
		logic gt;
	} cmp_t;

endpackage

/* sv/rational_arith_unit.sv */
// rational_arith_unit: top level of the rational arithmetic unit
// uses rau_pkg, rau_reduce and rau_mul
//
// usage
// - a request is taken at a rising edge with start high and busy low; it carries
//   a_num/a_den, b_num/b_den (raw signed 16-bit) and req_type (add, subtract,
//   multiply, divide)
// - busy stays high from the cycle after the request through the result cycle
// - the result shows on res_num, res_den, is_equal, is_less, is_greater for one
//   cycle with done high; there is no back pressure, the receiver must take it
// - each operand is reduced in turn by one reducer: a zero denominator gives 0/1
//   and skips the gcd, otherwise a binary gcd of shift/subtract steps is followed
//   by two restoring divisions by the gcd, all on a single 17-bit subtractor
// - then one 17x17 multiplier forms four products in turn, and a final step adds,
//   subtracts and compares
// - one request at a time, the next is taken no earlier than the cycle after done
// - reset clears the sequencers; result registers hold stale data until the
//   first done
module rational_arith_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [rau_pkg::OPW-1:0]    a_num,
	input  logic signed [rau_pkg::OPW-1:0]    a_den,
	input  logic signed [rau_pkg::OPW-1:0]    b_num,
	input  logic signed [rau_pkg::OPW-1:0]    b_den,
	input  logic [1:0]                        req_type,
	output logic                              done,
	output logic signed [rau_pkg::RNUMW-1:0]  res_num,
	output logic signed [rau_pkg::RDENW-1:0]  res_den,
	output logic                              is_equal,
	output logic                              is_less,
	output logic                              is_greater
);

	rau_pkg::top_state_t state_q, state_d;

	// second operand and opcode held while the first is reduced
	logic signed [rau_pkg::OPW-1:0] b_num_q, b_den_q;
	rau_pkg::op_t                   op_q;
	rau_pkg::frac_t                 fa_q;

	logic                           accept;
	logic                           red_start, red_done, mul_start, mul_done;
	logic signed [rau_pkg::OPW-1:0] red_n, red_d;
	rau_pkg::frac_t                 red_frac;
	rau_pkg::cmp_t                  cmp;

	assign accept = start && (state_q == rau_pkg::S_IDLE);
	assign busy   = (state_q != rau_pkg::S_IDLE);

	// reducer takes the first operand straight from the ports, the second from the hold regs
	assign red_start = accept || ((state_q == rau_pkg::S_RED_A) && red_done);
	assign red_n     = (state_q == rau_pkg::S_IDLE) ? a_num : b_num_q;
	assign red_d     = (state_q == rau_pkg::S_IDLE) ? a_den : b_den_q;
	assign mul_start = (state_q == rau_pkg::S_RED_B) && red_done;

	always_comb begin
		state_d = state_q;
		case (state_q)
			rau_pkg::S_IDLE: begin
				if (start) begin
					state_d = rau_pkg::S_RED_A;
				end
			end
			rau_pkg::S_RED_A: begin
				if (red_done) begin
					state_d = rau_pkg::S_RED_B;
				end
			end
			rau_pkg::S_RED_B: begin
				if (red_done) begin
					state_d = rau_pkg::S_MUL;
				end
			end
			rau_pkg::S_MUL: begin
				if (mul_done) begin
					state_d = rau_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rau_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rau_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			b_num_q <= b_num;
			b_den_q <= b_den;
			op_q    <= rau_pkg::op_t'(req_type);
		end
		// first reduced operand kept while the second is worked on
		if ((state_q == rau_pkg::S_RED_A) && red_done) begin
			fa_q <= red_frac;
		end
	end

	rau_reduce u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (red_start),
		.n      (red_n),
		.d      (red_d),
		.done   (red_done),
		.frac   (red_frac)
	);

	rau_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.fa      (fa_q),
		.fb      (red_frac),
		.op      (op_q),
		.done    (mul_done),
		.res_num (res_num),
		.res_den (res_den),
		.cmp     (cmp)
	);

	assign done       = mul_done;
	assign is_equal   = cmp.eq;
	assign is_less    = cmp.lt;
	assign is_greater = cmp.gt;

	// a result only comes out of the multiply phase
	a_done_from_mul: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == rau_pkg::S_MUL))
		else $error("result strobe outside multiply phase");

	// a taken request makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("request taken but block not busy");

	// reduced denominators are positive, so only divide can give a zero denominator
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (op_q != rau_pkg::OP_DIV)) |-> (res_den != '0))
		else $error("zero result denominator outside divide");

	// flags are mutually exclusive
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(is_less && is_greater) && !(is_equal && (is_less || is_greater)))
		else $error("conflicting comparison flags");

endmodule

/* sv/rau_reduce.sv */
// rau_reduce: reduces one signed fraction by binary gcd and two restoring divisions
// one shared subtractor does every compare and trial subtract; depends on rau_pkg
module rau_reduce (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic signed [rau_pkg::OPW-1:0]  n,
	input  logic signed [rau_pkg::OPW-1:0]  d,
	output logic                            done,
	output rau_pkg::frac_t                  frac
);

	rau_pkg::red_state_t state_q, state_d;
	logic done_q, done_d;

	logic [rau_pkg::MAGW-1:0] mn_q, md_q, x_q, y_q, g_q, rem_q, sh_q, qn_q;
	logic [rau_pkg::CNTW-1:0] k_q, cnt_q;
	logic                     neg_q;
	rau_pkg::frac_t           frac_q;

	logic [rau_pkg::MAGW-1:0] n_mag, d_mag, diff_mag, g_val, g_sel, q_next, rem_next;
	logic [rau_pkg::MAGW:0]   sub_a, sub_b;
	logic [rau_pkg::MAGW+1:0] sub_r;
	logic                     borrow, gcd_end, d_zero, q_bit;

	assign n_mag  = n[rau_pkg::OPW-1] ? (~n) + 1'b1 : n;
	assign d_mag  = d[rau_pkg::OPW-1] ? (~d) + 1'b1 : d;
	assign d_zero = (d == '0);

	// shared subtractor: gcd compare or divider trial subtract
	always_comb begin
		case (state_q)
			rau_pkg::R_GCD: begin
				sub_a = {1'b0, x_q};
				sub_b = {1'b0, y_q};
			end
			default: begin
				sub_a = {rem_q, sh_q[rau_pkg::MAGW-1]};
				sub_b = {1'b0, g_q};
			end
		endcase
	end

	assign sub_r    = {1'b0, sub_a} - {1'b0, sub_b};
	assign borrow   = sub_r[rau_pkg::MAGW+1];
	assign diff_mag = borrow ? (~sub_r[rau_pkg::MAGW-1:0]) + 1'b1 : sub_r[rau_pkg::MAGW-1:0];

	assign gcd_end = (x_q == '0) || (y_q == '0);
	assign g_sel   = (x_q == '0) ? y_q : x_q;
	assign g_val   = g_sel << k_q;

	// divider step
	assign q_bit    = !borrow;
	assign q_next   = {sh_q[rau_pkg::MAGW-2:0], q_bit};
	assign rem_next = q_bit ? sub_r[rau_pkg::MAGW-1:0] : sub_a[rau_pkg::MAGW-1:0];

	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		case (state_q)
			rau_pkg::R_IDLE: begin
				if (start) begin
					if (d_zero) begin
						done_d = 1'b1;
					end else begin
						state_d = rau_pkg::R_GCD;
					end
				end
			end
			rau_pkg::R_GCD: begin
				if (gcd_end) begin
					state_d = rau_pkg::R_DIVN;
				end
			end
			rau_pkg::R_DIVN: begin
				if (cnt_q == '0) begin
					state_d = rau_pkg::R_DIVD;
				end
			end
			rau_pkg::R_DIVD: begin
				if (cnt_q == '0) begin
					state_d = rau_pkg::R_IDLE;
					done_d  = 1'b1;
				end
			end
			default: begin
				state_d = rau_pkg::R_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rau_pkg::R_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rau_pkg::R_IDLE: begin
				if (start) begin
					mn_q  <= n_mag;
					md_q  <= d_mag;
					x_q   <= n_mag;
					y_q   <= d_mag;
					k_q   <= '0;
					neg_q <= n[rau_pkg::OPW-1] ^ d[rau_pkg::OPW-1];
					if (d_zero) begin
						frac_q.num <= '0;
						frac_q.den <= rau_pkg::MAGW'(1);
					end
				end
			end
			rau_pkg::R_GCD: begin
				if (gcd_end) begin
					g_q   <= g_val;
					rem_q <= '0;
					sh_q  <= mn_q;
					cnt_q <= rau_pkg::CNTW'(rau_pkg::MAGW - 1);
				end else if (!x_q[0] && !y_q[0]) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (!borrow) begin
					x_q <= diff_mag >> 1;
				end else begin
					y_q <= diff_mag >> 1;
				end
			end
			rau_pkg::R_DIVN: begin
				if (cnt_q == '0) begin
					qn_q  <= q_next;
					rem_q <= '0;
					sh_q  <= md_q;
					cnt_q <= rau_pkg::CNTW'(rau_pkg::MAGW - 1);
				end else begin
					cnt_q <= cnt_q - 1'b1;
					rem_q <= rem_next;
					sh_q  <= q_next;
				end
			end
			rau_pkg::R_DIVD: begin
				cnt_q <= cnt_q - 1'b1;
				rem_q <= rem_next;
				sh_q  <= q_next;
				if (cnt_q == '0) begin
					frac_q.den <= q_next;
					// sign goes to the numerator unless it is zero
					if (neg_q && (qn_q != '0)) begin
						frac_q.num <= -$signed({1'b0, qn_q});
					end else begin
						frac_q.num <= $signed({1'b0, qn_q});
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign frac = frac_q;

endmodule

/* sv/rau_mul.sv */
// rau_mul: cross multiplication of two reduced fractions on one shared multiplier
// four products in turn, then add/subtract or select, and compare; depends on rau_pkg
module rau_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  rau_pkg::frac_t                      fa,
	input  rau_pkg::frac_t                      fb,
	input  rau_pkg::op_t                        op,
	output logic                                done,
	output logic signed [rau_pkg::RNUMW-1:0]    res_num,
	output logic signed [rau_pkg::RDENW-1:0]    res_den,
	output rau_pkg::cmp_t                       cmp
);

	logic       run_q, fin_q, done_q;
	logic [1:0] step_q;

	rau_pkg::frac_t fa_q, fb_q;
	rau_pkg::op_t   op_q;

	logic signed [rau_pkg::NUMW-1:0]  mul_a, mul_b, ad_s, bd_s;
	logic signed [rau_pkg::PRODW-1:0] prod;
	logic signed [rau_pkg::PRODW-1:0] an_bd_q, bn_ad_q, pnum_q, pden_q, rn_full;

	logic signed [rau_pkg::RNUMW-1:0] res_num_q;
	logic signed [rau_pkg::RDENW-1:0] res_den_q;
	rau_pkg::cmp_t                    cmp_q;

	assign ad_s = $signed({1'b0, fa_q.den});
	assign bd_s = $signed({1'b0, fb_q.den});

	// operand select per step
	always_comb begin
		case (step_q)
			2'd0: begin
				mul_a = fa_q.num;
				mul_b = bd_s;
			end
			2'd1: begin
				mul_a = fb_q.num;
				mul_b = ad_s;
			end
			2'd2: begin
				mul_a = fa_q.num;
				mul_b = fb_q.num;
			end
			default: begin
				mul_a = ad_s;
				mul_b = (op_q == rau_pkg::OP_DIV) ? fb_q.num : bd_s;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	always_comb begin
		case (op_q)
			rau_pkg::OP_ADD: rn_full = an_bd_q + bn_ad_q;
			rau_pkg::OP_SUB: rn_full = an_bd_q - bn_ad_q;
			rau_pkg::OP_MUL: rn_full = pnum_q;
			default:         rn_full = an_bd_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == 2'd3) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			fa_q <= fa;
			fb_q <= fb;
			op_q <= op;
		end
		if (run_q) begin
			case (step_q)
				2'd0:    an_bd_q <= prod;
				2'd1:    bn_ad_q <= prod;
				2'd2:    pnum_q  <= prod;
				default: pden_q  <= prod;
			endcase
		end
		if (fin_q) begin
			res_num_q <= rn_full[rau_pkg::RNUMW-1:0];
			res_den_q <= pden_q[rau_pkg::RDENW-1:0];
			cmp_q.eq  <= (fa_q == fb_q);
			cmp_q.lt  <= (an_bd_q < bn_ad_q);
			cmp_q.gt  <= (bn_ad_q < an_bd_q);
		end
	end

	assign done    = done_q;
	assign res_num = res_num_q;
	assign res_den = res_den_q;
	assign cmp     = cmp_q;

endmodule

/* test/tb_rational_arith_unit.sv */
// tb_rational_arith_unit: self-checking testbench of the rational arithmetic unit
// depends on rau_pkg and rational_arith_unit; sends directed, then random requests
// and checks every result against a predictor that reduces and cross multiplies, or a hand value
module tb_rational_arith_unit;
	timeunit 1ns;
	timeprecision 1ps;

	// cycles without any handshake before the run is declared hung
	localparam int HANG_LIMIT    = 3000;
	// cycles to wait after the last result for any stray done
	localparam int TAIL_CYCLES   = 200;
	localparam int RANDOM_ITEMS  = 630;
	localparam int REPORT_LIMIT  = 10;

	// one result as the unit should present it
	typedef struct {
		logic signed [rau_pkg::RNUMW-1:0] num;
		logic signed [rau_pkg::RDENW-1:0] den;
		logic                             eq;
		logic                             lt;
		logic                             gt;
	} frac_result_t;

	// one request plus the result it must produce
	typedef struct {
		logic signed [rau_pkg::OPW-1:0] an;
		logic signed [rau_pkg::OPW-1:0] ad;
		logic signed [rau_pkg::OPW-1:0] bn;
		logic signed [rau_pkg::OPW-1:0] bd;
		rau_pkg::op_t                   op;
		frac_result_t                   want;
	} request_t;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             start;
	logic                             busy;
	logic signed [rau_pkg::OPW-1:0]   a_num;
	logic signed [rau_pkg::OPW-1:0]   a_den;
	logic signed [rau_pkg::OPW-1:0]   b_num;
	logic signed [rau_pkg::OPW-1:0]   b_den;
	logic [1:0]                       req_type;
	logic                             done;
	logic signed [rau_pkg::RNUMW-1:0] res_num;
	logic signed [rau_pkg::RDENW-1:0] res_den;
	logic                             is_equal;
	logic                             is_less;
	logic                             is_greater;

	// results still owed by the unit, oldest first
	frac_result_t awaited_results[$];
	request_t     directed_rows[$];

	int requests_sent   = 0;
	int results_checked = 0;
	int zero_den_count  = 0;
	int mismatches      = 0;
	int hang_count      = 0;

	rational_arith_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.a_num      (a_num),
		.a_den      (a_den),
		.b_num      (b_num),
		.b_den      (b_den),
		.req_type   (req_type),
		.done       (done),
		.res_num    (res_num),
		.res_den    (res_den),
		.is_equal   (is_equal),
		.is_less    (is_less),
		.is_greater (is_greater)
	);

	always #5 clk = ~clk;

	// bring a raw fraction to lowest terms with a positive denominator;
	// a zero denominator means 0/1
	function automatic void lowest_terms(input logic signed [rau_pkg::OPW-1:0] n_raw,
	                                     input logic signed [rau_pkg::OPW-1:0] d_raw,
	                                     output longint num, output longint den);
		longint n, d, mn, md, x, y, t;
		n = n_raw;
		d = d_raw;
		if (d == 0) begin
			num = 0;
			den = 1;
		end else begin
			mn = (n < 0) ? -n : n;
			md = (d < 0) ? -d : d;
			x = mn;
			y = md;
			// euclid on the magnitudes
			while (y != 0) begin
				t = x % y;
				x = y;
				y = t;
			end
			mn = mn / x;
			md = md / x;
			// sign goes to the numerator, a zero numerator stays non-negative
			num = (((n < 0) != (d < 0)) && mn != 0) ? -mn : mn;
			den = md;
		end
	endfunction

	// expected result of one request: cross products of the reduced operands,
	// result left unreduced, flags from the exact cross products
	function automatic frac_result_t rational_op(
		input logic signed [rau_pkg::OPW-1:0] an_raw,
		input logic signed [rau_pkg::OPW-1:0] ad_raw,
		input logic signed [rau_pkg::OPW-1:0] bn_raw,
		input logic signed [rau_pkg::OPW-1:0] bd_raw,
		input rau_pkg::op_t op);
		longint an, ad, bn, bd, cross_a, cross_b, rn, rd;
		frac_result_t r;
		lowest_terms(an_raw, ad_raw, an, ad);
		lowest_terms(bn_raw, bd_raw, bn, bd);
		cross_a = an * bd;
		cross_b = bn * ad;
		case (op)
			rau_pkg::OP_ADD: begin
				rn = cross_a + cross_b;
				rd = ad * bd;
			end
			rau_pkg::OP_SUB: begin
				rn = cross_a - cross_b;
				rd = ad * bd;
			end
			rau_pkg::OP_MUL: begin
				rn = an * bn;
				rd = ad * bd;
			end
			default: begin
				// divide: flipping the second operand, so its numerator
				// lands in the denominator with its sign
				rn = cross_a;
				rd = ad * bn;
			end
		endcase
		r.num = rn[rau_pkg::RNUMW-1:0];
		r.den = rd[rau_pkg::RDENW-1:0];
		r.eq  = (an == bn) && (ad == bd);
		r.lt  = cross_a < cross_b;
		r.gt  = cross_b < cross_a;
		return r;
	endfunction

	function automatic request_t make_request(input int an, input int ad, input int bn,
	                                          input int bd, input rau_pkg::op_t op);
		request_t r;
		r.an   = rau_pkg::OPW'(an);
		r.ad   = rau_pkg::OPW'(ad);
		r.bn   = rau_pkg::OPW'(bn);
		r.bd   = rau_pkg::OPW'(bd);
		r.op   = op;
		r.want = rational_op(r.an, r.ad, r.bn, r.bd, op);
		return r;
	endfunction

	// directed row checked by the predictor
	task automatic add_row(input int an, input int ad, input int bn, input int bd,
	                       input rau_pkg::op_t op);
		directed_rows.push_back(make_request(an, ad, bn, bd, op));
	endtask

	// directed row with the result written out by hand
	task automatic add_known(input int an, input int ad, input int bn, input int bd,
	                         input rau_pkg::op_t op, input longint num, input longint den,
	                         input bit eq, input bit lt, input bit gt);
		request_t r;
		r = make_request(an, ad, bn, bd, op);
		r.want.num = num[rau_pkg::RNUMW-1:0];
		r.want.den = den[rau_pkg::RDENW-1:0];
		r.want.eq  = eq;
		r.want.lt  = lt;
		r.want.gt  = gt;
		directed_rows.push_back(r);
	endtask

	// present one request and hold it until the unit takes it; a random gap
	// may come first when idling is allowed
	task automatic issue_request(input request_t r, input bit may_idle);
		int gap;
		if (may_idle && $urandom_range(99) < 6) begin
			gap = $urandom_range(1, 12);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		a_num    <= r.an;
		a_den    <= r.ad;
		b_num    <= r.bn;
		b_den    <= r.bd;
		req_type <= r.op;
		// taken at the first edge that sees busy low
		do @(posedge clk); while (busy);
		awaited_results.push_back(r.want);
		requests_sent++;
		if (r.ad == 0 || r.bd == 0)
			zero_den_count++;
	endtask

	// sender holds off until the unit has delivered everything owed
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (awaited_results.size() != 0);
	endtask

	// random operand set, biased toward shared factors, zero denominators,
	// extremes and equal fractions so the reducer sees more than coprime noise
	function automatic request_t random_request();
		int edge_vals[8] = '{-32768, -32767, -1, 0, 1, 2, 32766, 32767};
		int mode, k, m, an, ad;
		rau_pkg::op_t op;
		request_t r;
		mode = $urandom_range(99);
		op   = rau_pkg::op_t'($urandom_range(3));
		if (mode < 35) begin
			r = make_request($urandom(), $urandom(), $urandom(), $urandom(), op);
		end else if (mode < 60) begin
			r = make_request(int'($urandom_range(128)) - 64, int'($urandom_range(128)) - 64,
			                 int'($urandom_range(128)) - 64, int'($urandom_range(128)) - 64,
			                 op);
		end else if (mode < 78) begin
			// both parts share a factor k
			k = $urandom_range(1, 200);
			r = make_request(k * (int'($urandom_range(300)) - 150),
			                 k * (int'($urandom_range(300)) - 150),
			                 k * (int'($urandom_range(300)) - 150),
			                 k * (int'($urandom_range(300)) - 150), op);
		end else if (mode < 90) begin
			r = make_request(edge_vals[$urandom_range(7)], edge_vals[$urandom_range(7)],
			                 edge_vals[$urandom_range(7)], edge_vals[$urandom_range(7)], op);
		end else begin
			// second operand is the first scaled, so the reduced forms match
			an = int'($urandom_range(2000)) - 1000;
			ad = int'($urandom_range(2000)) - 1000;
			m  = int'($urandom_range(1, 8)) * ($urandom_range(1) ? 1 : -1);
			r  = make_request(an, ad, an * m, ad * m, op);
		end
		return r;
	endfunction

	// stimulus
	initial begin
		request_t r;
		arst_n   = 1'b0;
		start    = 1'b0;
		a_num    = '0;
		a_den    = '0;
		b_num    = '0;
		b_den    = '0;
		req_type = rau_pkg::OP_ADD;

		// hand-worked rows: zero denominators, most negative operand, divide by zero
		add_known(0, 0, 0, 0, rau_pkg::OP_ADD, 0, 1, 1, 0, 0);
		add_known(-32768, -1, 1, 0, rau_pkg::OP_MUL, 0, 1, 0, 0, 1);
		add_known(-32768, -1, -32768, -1, rau_pkg::OP_MUL, 1073741824, 1, 1, 0, 0);
		add_known(-32768, -1, -32768, 1, rau_pkg::OP_SUB, 65536, 1, 0, 0, 1);
		add_known(3, 4, 0, 5, rau_pkg::OP_DIV, 3, 0, 0, 0, 1);
		add_known(5, -10, -1, 2, rau_pkg::OP_ADD, -4, 4, 1, 0, 0);
		add_known(6, 0, 0, -7, rau_pkg::OP_SUB, 0, 1, 1, 0, 0);
		add_known(-32768, -32768, 1, 1, rau_pkg::OP_DIV, 1, 1, 1, 0, 0);
		add_known(1, 2, -1, -3, rau_pkg::OP_DIV, 3, 2, 0, 0, 1);
		add_known(-1, 2, 1, -3, rau_pkg::OP_DIV, -3, -2, 0, 1, 0);
		// wide cross products and long gcd chains, left to the predictor
		add_row(32767, -32768, -32768, 32767, rau_pkg::OP_ADD);
		add_row(-32767, -32768, -32768, 32767, rau_pkg::OP_SUB);
		add_row(32767, 1, -32768, -32767, rau_pkg::OP_SUB);
		add_row(-32768, 32767, -32768, 32767, rau_pkg::OP_MUL);
		add_row(32767, 32767, -32768, -32768, rau_pkg::OP_DIV);
		add_row(12345, -6789, 1000, 250, rau_pkg::OP_ADD);
		add_row(-21845, -32767, 16384, -24576, rau_pkg::OP_SUB);
		add_row(21845, -21846, -21846, 21845, rau_pkg::OP_MUL);
		add_row(7, 9, 1, 0, rau_pkg::OP_DIV);
		add_row(-32768, 32767, 0, -32768, rau_pkg::OP_DIV);
		add_row(1, -1, 32767, 32766, rau_pkg::OP_SUB);
		add_row(-28657, 17711, 28657, -17711, rau_pkg::OP_ADD);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			issue_request(directed_rows[i], 1'b1);

		// let the directed part finish before random traffic
		drain_results();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			r = random_request();
			// a stretch of back-to-back requests with no idling
			issue_request(r, !(i >= 250 && i < 400));
			if (i == 450)
				drain_results();
		end
		start <= 1'b0;

		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d requests (%0d directed, %0d with a zero denominator)",
		         requests_sent, directed_rows.size(), zero_den_count);
		$display("compared %0d results, %0d mismatches", results_checked, mismatches);
		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// result check: every done cycle is matched against the oldest expectation
	always @(posedge clk) begin
		frac_result_t want;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				// result with no request outstanding
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result num %0d den %0d at %t", res_num, res_den,
					         $realtime);
			end else begin
				want = awaited_results.pop_front();
				results_checked++;
				if (res_num !== want.num || res_den !== want.den || is_equal !== want.eq
				    || is_less !== want.lt || is_greater !== want.gt) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("mismatch on result %0d: want %0d/%0d eq %b lt %b gt %b",
						         results_checked, want.num, want.den, want.eq, want.lt,
						         want.gt);
						$display("  got %0d/%0d eq %b lt %b gt %b",
						         res_num, res_den, is_equal, is_less, is_greater);
					end
				end
			end
		end
	end

	// hang detection: no request taken and no result for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				hang_count <= 0;
			end else if (hang_count >= HANG_LIMIT) begin
				$display("no handshake for %0d cycles, giving up", HANG_LIMIT);
				$display("simulation failed");
				$finish;
			end else begin
				hang_count <= hang_count + 1;
			end
		end
	end

endmodule

/* files.f */
sv/rau_pkg.sv
sv/rau_reduce.sv
sv/rau_mul.sv
sv/rational_arith_unit.sv
test/tb_rational_arith_unit.sv
